@@ hw/rtl/shcs_pkg.sv @@
// Shared types, codes and frame tables for the stepper homing command sequencer.
// No dependencies; every other file of the block but shcs_if uses it.
`timescale 1ns / 1ps

package shcs_pkg;

   localparam int CFG_W  = 10;
   localparam int ADDR_W = 8;
   localparam int CSR_INDEX_W = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_ADDRESS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_ADDRESS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS   = 3'd4;

   localparam logic [ADDR_W-1:0] Y_ADDRESS_RESET      = 8'd1;
   localparam logic [ADDR_W-1:0] X_ADDRESS_RESET      = 8'd1;
   localparam logic [CFG_W-1:0]  DEBOUNCE_TICKS_RESET = 10'd20;
   localparam logic [CFG_W-1:0]  GAP_TICKS_RESET      = 10'd20;
   localparam logic [CFG_W-1:0]  SETTLE_TICKS_RESET   = 10'd100;

   // frame bytes
   localparam logic [7:0] Y_TAIL        = 8'h6B;
   localparam logic [7:0] X_HEAD        = 8'hFA;
   localparam logic [7:0] OP_Y_ENABLE   = 8'hF3;
   localparam logic [7:0] ARG_Y_ENABLE  = 8'hAB;
   localparam logic [7:0] OP_HOME       = 8'h9A;
   localparam logic [7:0] OP_Y_SPEED    = 8'hF6;
   localparam logic [7:0] OP_Y_STOP     = 8'hFE;
   localparam logic [7:0] ARG_Y_STOP    = 8'h98;
   localparam logic [7:0] OP_X_WORK     = 8'h82;
   localparam logic [7:0] OP_X_LEVEL    = 8'h85;
   localparam logic [7:0] OP_X_GO_HOME  = 8'h91;
   localparam logic [7:0] ARG_X_MODE    = 8'h02;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_INIT     = 3'd1,
      CMD_ENABLE_Y = 3'd2,
      CMD_RUN_Y    = 3'd3,
      CMD_STOP_Y   = 3'd4,
      CMD_SET_X_EN = 3'd5
   } command_type;

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_Y_ENABLE,
      JOB_Y_SPEED,
      JOB_Y_STOP,
      JOB_Y_HOME,
      JOB_INIT,
      JOB_X_HOME,
      JOB_X_WORK
   } job_kind_type;

   typedef enum logic [2:0] {
      FR_Y_ENABLE,
      FR_Y_HOME,
      FR_Y_SPEED,
      FR_Y_STOP,
      FR_X_LEVEL_LOW,
      FR_X_WORK,
      FR_X_HOME_MODE,
      FR_X_GO_HOME
   } frame_kind_type;

   typedef enum logic [3:0] {
      SRC_LIT,
      SRC_Y_ADDR,
      SRC_X_ADDR,
      SRC_ENABLE,
      SRC_DIR,
      SRC_RPM_HI,
      SRC_RPM_LO,
      SRC_ACC,
      SRC_SUM
   } byte_src_type;

   typedef struct packed {
      byte_src_type src;
      logic [7:0]   lit;
   } byte_item_type;

   // one queued job: what to send plus the status that goes with every byte
   typedef struct packed {
      job_kind_type kind;
      logic         enable;
      logic         direction;
      logic [15:0]  y_speed;
      logic [7:0]   acceleration;
      logic         busy;
      logic         x_enable_pin;
   } job_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] gap_ticks;
      logic [CFG_W-1:0] settle_ticks;
   } timer_cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] y_address;
      logic [ADDR_W-1:0] x_address;
   } addr_cfg_type;

   function automatic byte_item_type frame_item(frame_kind_type f, logic [2:0] i);
      byte_item_type r;
      r.src = SRC_LIT;
      r.lit = 8'h00;
      case (f)
         FR_Y_ENABLE: begin
            case (i)
               3'd0: r.src = SRC_Y_ADDR;
               3'd1: r.lit = OP_Y_ENABLE;
               3'd2: r.lit = ARG_Y_ENABLE;
               3'd3: r.src = SRC_ENABLE;
               3'd5: r.lit = Y_TAIL;
               default: ;
            endcase
         end
         FR_Y_HOME: begin
            case (i)
               3'd0: r.src = SRC_Y_ADDR;
               3'd1: r.lit = OP_HOME;
               3'd4: r.lit = Y_TAIL;
               default: ;
            endcase
         end
         FR_Y_SPEED: begin
            case (i)
               3'd0: r.src = SRC_Y_ADDR;
               3'd1: r.lit = OP_Y_SPEED;
               3'd2: r.src = SRC_DIR;
               3'd3: r.src = SRC_RPM_HI;
               3'd4: r.src = SRC_RPM_LO;
               3'd5: r.src = SRC_ACC;
               3'd7: r.lit = Y_TAIL;
               default: ;
            endcase
         end
         FR_Y_STOP: begin
            case (i)
               3'd0: r.src = SRC_Y_ADDR;
               3'd1: r.lit = OP_Y_STOP;
               3'd2: r.lit = ARG_Y_STOP;
               3'd4: r.lit = Y_TAIL;
               default: ;
            endcase
         end
         FR_X_LEVEL_LOW: begin
            case (i)
               3'd0: r.lit = X_HEAD;
               3'd1: r.src = SRC_X_ADDR;
               3'd2: r.lit = OP_X_LEVEL;
               3'd4: r.src = SRC_SUM;
               default: ;
            endcase
         end
         FR_X_WORK: begin
            case (i)
               3'd0: r.lit = X_HEAD;
               3'd1: r.src = SRC_X_ADDR;
               3'd2: r.lit = OP_X_WORK;
               3'd3: r.lit = ARG_X_MODE;
               3'd4: r.src = SRC_SUM;
               default: ;
            endcase
         end
         FR_X_HOME_MODE: begin
            case (i)
               3'd0: r.lit = X_HEAD;
               3'd1: r.src = SRC_X_ADDR;
               3'd2: r.lit = OP_HOME;
               3'd3: r.lit = ARG_X_MODE;
               3'd4: r.lit = ARG_X_MODE;
               3'd5: r.lit = ARG_X_MODE;
               3'd7: r.src = SRC_SUM;
               default: ;
            endcase
         end
         FR_X_GO_HOME: begin
            case (i)
               3'd0: r.lit = X_HEAD;
               3'd1: r.src = SRC_X_ADDR;
               3'd2: r.lit = OP_X_GO_HOME;
               3'd4: r.src = SRC_SUM;
               default: ;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] frame_last_index(frame_kind_type f);
      logic [2:0] r;
      case (f)
         FR_Y_ENABLE:    r = 3'd5;
         FR_Y_SPEED:     r = 3'd7;
         FR_X_HOME_MODE: r = 3'd7;
         default:        r = 3'd4;
      endcase
      return r;
   endfunction

   function automatic logic frame_port(frame_kind_type f);
      logic r;
      case (f)
         FR_X_LEVEL_LOW, FR_X_WORK, FR_X_HOME_MODE, FR_X_GO_HOME: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic frame_kind_type job_frame(job_kind_type k, logic [1:0] fi);
      frame_kind_type r;
      case (k)
         JOB_Y_SPEED: r = FR_Y_SPEED;
         JOB_Y_STOP:  r = FR_Y_STOP;
         JOB_Y_HOME:  r = FR_Y_HOME;
         JOB_X_WORK:  r = FR_X_WORK;
         JOB_X_HOME:  r = (fi == 2'd0) ? FR_X_HOME_MODE : FR_X_GO_HOME;
         JOB_INIT: begin
            case (fi)
               2'd0:    r = FR_Y_ENABLE;
               2'd1:    r = FR_X_LEVEL_LOW;
               default: r = FR_X_WORK;
            endcase
         end
         default: r = FR_Y_ENABLE;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] job_last_frame(job_kind_type k);
      logic [1:0] r;
      case (k)
         JOB_INIT:   r = 2'd2;
         JOB_X_HOME: r = 2'd1;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/shcs_if.sv @@
// Channel interfaces of the stepper homing command sequencer: request,
// response and register write. Depends on nothing.
`timescale 1ns / 1ps

interface shcs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic        key_level;
   logic        enable;
   logic        direction;
   logic [15:0] y_speed;
   logic [7:0]  acceleration;

   modport source (output valid, command, key_level, enable, direction, y_speed,
                   acceleration, input ready);
   modport sink (input valid, command, key_level, enable, direction, y_speed,
                 acceleration, output ready);
endinterface

interface shcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       port;
   logic       byte_valid;
   logic [7:0] tx_byte;
   logic       last;
   logic       busy_res;
   logic       x_enable_pin;

   modport source (output valid, port, byte_valid, tx_byte, last, busy_res,
                   x_enable_pin, input ready);
   modport sink (input valid, port, byte_valid, tx_byte, last, busy_res,
                 x_enable_pin, output ready);
endinterface

interface shcs_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/shcs_front.sv @@
// Front end: key debounce, start sequence timing and X pin level; turns each
// accepted request into a job. Depends on shcs_pkg and shcs_if.
`timescale 1ns / 1ps

module shcs_front #(
   parameter int TIMER_WIDTH = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   shcs_req_if.sink                req_chan,
   input  shcs_pkg::timer_cfg_type timer_cfg,
   input  logic                    queue_full,
   output logic                    push,
   output shcs_pkg::job_type       push_job
);

   localparam int CW = (TIMER_WIDTH > shcs_pkg::CFG_W) ? TIMER_WIDTH : shcs_pkg::CFG_W;
   localparam logic [CW-1:0] TMAX_C = CW'((1 << TIMER_WIDTH) - 1);

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_EN_Y,
      STEP_EN_X,
      STEP_HOME_Y,
      STEP_HOME_X,
      STEP_RESTORE
   } step_type;

   function automatic logic [TIMER_WIDTH-1:0] clamp_t(logic [shcs_pkg::CFG_W-1:0] v);
      logic [CW-1:0] ve;
      ve = CW'(v);
      return TIMER_WIDTH'((ve > TMAX_C) ? TMAX_C : ve);
   endfunction

   step_type               step_ff, step_in;
   logic [TIMER_WIDTH-1:0] wait_ff, wait_in;
   logic [TIMER_WIDTH-1:0] debounce_ff, debounce_in;
   logic                   prev_ff, prev_in;
   logic                   stable_ff, stable_in;
   logic                   xpin_ff, xpin_in;
   logic                   accept;
   logic [TIMER_WIDTH-1:0] debounce_lim, gap_lim, settle_lim;
   shcs_pkg::job_type      job;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign push           = accept;
   assign push_job       = job;

   assign debounce_lim = clamp_t(timer_cfg.debounce_ticks);
   assign gap_lim      = clamp_t(timer_cfg.gap_ticks);
   assign settle_lim   = clamp_t(timer_cfg.settle_ticks);

   always_comb begin
      step_in     = step_ff;
      wait_in     = wait_ff;
      debounce_in = debounce_ff;
      prev_in     = prev_ff;
      stable_in   = stable_ff;
      xpin_in     = xpin_ff;

      job.kind         = shcs_pkg::JOB_NONE;
      job.enable       = req_chan.enable;
      job.direction    = req_chan.direction;
      job.y_speed      = req_chan.y_speed;
      job.acceleration = req_chan.acceleration;

      case (req_chan.command)
         shcs_pkg::CMD_TICK: begin
            if (req_chan.key_level != prev_ff) begin
               prev_in     = req_chan.key_level;
               debounce_in = '0;
            end else if (debounce_ff < debounce_lim) begin
               debounce_in = debounce_ff + 1'b1;
            end else if (req_chan.key_level != stable_ff) begin
               stable_in = req_chan.key_level;
               if (!req_chan.key_level && step_ff == STEP_IDLE) begin
                  step_in = STEP_EN_Y;
                  wait_in = '0;
               end
            end
            // a press that starts the sequence acts on this same tick
            if (wait_in != '0) begin
               wait_in = wait_in - 1'b1;
            end else begin
               case (step_in)
                  STEP_EN_Y: begin
                     job.kind   = shcs_pkg::JOB_Y_ENABLE;
                     job.enable = 1'b1;
                     step_in    = STEP_EN_X;
                     wait_in    = gap_lim;
                  end
                  STEP_EN_X: begin
                     xpin_in = 1'b0;
                     step_in = STEP_HOME_Y;
                     wait_in = settle_lim;
                  end
                  STEP_HOME_Y: begin
                     job.kind = shcs_pkg::JOB_Y_HOME;
                     step_in  = STEP_HOME_X;
                     wait_in  = gap_lim;
                  end
                  STEP_HOME_X: begin
                     job.kind = shcs_pkg::JOB_X_HOME;
                     step_in  = STEP_RESTORE;
                     wait_in  = gap_lim;
                  end
                  STEP_RESTORE: begin
                     job.kind = shcs_pkg::JOB_X_WORK;
                     step_in  = STEP_IDLE;
                  end
                  default: ;
               endcase
            end
         end
         shcs_pkg::CMD_INIT: begin
            step_in    = STEP_IDLE;
            wait_in    = '0;
            xpin_in    = 1'b1;
            job.kind   = shcs_pkg::JOB_INIT;
            job.enable = 1'b0;
         end
         shcs_pkg::CMD_ENABLE_Y: job.kind = shcs_pkg::JOB_Y_ENABLE;
         shcs_pkg::CMD_RUN_Y:    job.kind = shcs_pkg::JOB_Y_SPEED;
         shcs_pkg::CMD_STOP_Y:   job.kind = shcs_pkg::JOB_Y_STOP;
         shcs_pkg::CMD_SET_X_EN: xpin_in  = !req_chan.enable;
         default: ;
      endcase

      job.busy         = (step_in != STEP_IDLE);
      job.x_enable_pin = xpin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_IDLE;
         wait_ff     <= '0;
         debounce_ff <= '0;
         prev_ff     <= 1'b1;
         stable_ff   <= 1'b1;
         xpin_ff     <= 1'b1;
      end else if (accept) begin
         step_ff     <= step_in;
         wait_ff     <= wait_in;
         debounce_ff <= debounce_in;
         prev_ff     <= prev_in;
         stable_ff   <= stable_in;
         xpin_ff     <= xpin_in;
      end
   end

endmodule

@@ hw/rtl/shcs_queue.sv @@
// Two-entry job queue between the front end and the byte serializer.
// Depends on shcs_pkg.
`timescale 1ns / 1ps

module shcs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  shcs_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output shcs_pkg::job_type head_job
);

   shcs_pkg::job_type                entry_ff [shcs_pkg::QUEUE_DEPTH];
   logic [shcs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [shcs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [shcs_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == shcs_pkg::QCNT_W'(shcs_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/shcs_back.sv @@
// Back end: walks the queue head frame by frame and emits one registered
// response per cycle while ready is high. Depends on shcs_pkg, shcs_if.
`timescale 1ns / 1ps

module shcs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  shcs_pkg::addr_cfg_type addr_cfg,
   input  logic                   head_valid,
   input  shcs_pkg::job_type      head_job,
   output logic                   pop,
   shcs_rsp_if.source             rsp_chan
);

   logic [1:0]                frame_idx_ff, frame_idx_in;
   logic [2:0]                byte_idx_ff, byte_idx_in;
   logic [7:0]                sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_port_ff, rsp_port_in;
   logic                      rsp_byte_valid_ff, rsp_byte_valid_in;
   logic [7:0]                rsp_tx_byte_ff, rsp_tx_byte_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_busy_ff, rsp_busy_in;
   logic                      rsp_xpin_ff, rsp_xpin_in;

   shcs_pkg::frame_kind_type  frame;
   shcs_pkg::byte_item_type   item;
   logic [7:0]                cur_byte;
   logic                      is_none, frame_done, job_done, advance;

   assign frame      = shcs_pkg::job_frame(head_job.kind, frame_idx_ff);
   assign item       = shcs_pkg::frame_item(frame, byte_idx_ff);
   assign is_none    = (head_job.kind == shcs_pkg::JOB_NONE);
   assign frame_done = (byte_idx_ff == shcs_pkg::frame_last_index(frame));
   assign job_done   = is_none ||
                       (frame_done && frame_idx_ff == shcs_pkg::job_last_frame(head_job.kind));
   assign advance    = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop        = advance && job_done;

   always_comb begin
      case (item.src)
         shcs_pkg::SRC_Y_ADDR: cur_byte = addr_cfg.y_address;
         shcs_pkg::SRC_X_ADDR: cur_byte = addr_cfg.x_address;
         shcs_pkg::SRC_ENABLE: cur_byte = {7'd0, head_job.enable};
         shcs_pkg::SRC_DIR:    cur_byte = {7'd0, head_job.direction};
         shcs_pkg::SRC_RPM_HI: cur_byte = head_job.y_speed[15:8];
         shcs_pkg::SRC_RPM_LO: cur_byte = head_job.y_speed[7:0];
         shcs_pkg::SRC_ACC:    cur_byte = head_job.acceleration;
         shcs_pkg::SRC_SUM:    cur_byte = sum_ff;
         default:              cur_byte = item.lit;
      endcase
   end

   always_comb begin
      frame_idx_in      = frame_idx_ff;
      byte_idx_in       = byte_idx_ff;
      sum_in            = sum_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_port_in       = rsp_port_ff;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_tx_byte_in    = rsp_tx_byte_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_busy_in       = rsp_busy_ff;
      rsp_xpin_in       = rsp_xpin_ff;
      if (advance) begin
         rsp_valid_in      = 1'b1;
         rsp_port_in       = !is_none && shcs_pkg::frame_port(frame);
         rsp_byte_valid_in = !is_none;
         rsp_tx_byte_in    = is_none ? 8'd0 : cur_byte;
         rsp_last_in       = job_done;
         rsp_busy_in       = head_job.busy;
         rsp_xpin_in       = head_job.x_enable_pin;
         // checksum restarts at each frame head
         sum_in = (byte_idx_ff == '0) ? cur_byte : sum_ff + cur_byte;
         if (job_done) begin
            frame_idx_in = '0;
            byte_idx_in  = '0;
         end else if (frame_done) begin
            frame_idx_in = frame_idx_ff + 1'b1;
            byte_idx_in  = '0;
         end else begin
            byte_idx_in = byte_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_idx_ff <= '0;
         byte_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_idx_ff <= frame_idx_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff            <= sum_in;
      rsp_port_ff       <= rsp_port_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_tx_byte_ff    <= rsp_tx_byte_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_busy_ff       <= rsp_busy_in;
      rsp_xpin_ff       <= rsp_xpin_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.port         = rsp_port_ff;
   assign rsp_chan.byte_valid   = rsp_byte_valid_ff;
   assign rsp_chan.tx_byte      = rsp_tx_byte_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.busy_res     = rsp_busy_ff;
   assign rsp_chan.x_enable_pin = rsp_xpin_ff;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_byte_valid_ff |-> rsp_last_ff)
      else $error("byte-less response not marked last");

   a_byte_in_frame: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> byte_idx_ff <= shcs_pkg::frame_last_index(frame))
      else $error("byte index past end of frame");

   a_frame_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> frame_idx_ff <= shcs_pkg::job_last_frame(head_job.kind))
      else $error("frame index past end of job");

   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> frame_idx_ff == '0 && byte_idx_ff == '0)
      else $error("indexes not rewound after job");

endmodule

@@ hw/rtl/stepper_homing_command_sequencer_unit.sv @@
// Top level of the stepper homing command sequencer: register file, front end,
// job queue and byte serializer. Depends on shcs_pkg, shcs_if and the shcs_ modules.
`timescale 1ns / 1ps

// Each request (tick or command) yields 1 to 16 response items, one frame byte
// each, or a single byte-less item marked last when nothing is sent. The front
// end takes a request every cycle while the two-entry job queue has room; the
// serializer emits one byte per cycle while the response port is ready. A request
// without frames gives one item, one frame 5 to 8 bytes, X homing 13 and init
// 16. Register writes are always accepted and registered.
module stepper_homing_command_sequencer_unit #(
   parameter int TIMER_WIDTH = 10
) (
   input  logic       clock,
   input  logic       reset,
   shcs_req_if.sink   req_chan,
   shcs_rsp_if.source rsp_chan,
   shcs_csr_if.sink   csr_chan
);

   logic [shcs_pkg::ADDR_W-1:0] y_address_ff, x_address_ff;
   logic [shcs_pkg::CFG_W-1:0]  debounce_ff, gap_ff, settle_ff;
   shcs_pkg::timer_cfg_type     timer_cfg;
   shcs_pkg::addr_cfg_type      addr_cfg;
   logic                        push, pop, full, head_valid;
   shcs_pkg::job_type           push_job, head_job;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_address_ff <= shcs_pkg::Y_ADDRESS_RESET;
         x_address_ff <= shcs_pkg::X_ADDRESS_RESET;
         debounce_ff  <= shcs_pkg::DEBOUNCE_TICKS_RESET;
         gap_ff       <= shcs_pkg::GAP_TICKS_RESET;
         settle_ff    <= shcs_pkg::SETTLE_TICKS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            shcs_pkg::CSR_Y_ADDRESS:      y_address_ff <= csr_chan.data[shcs_pkg::ADDR_W-1:0];
            shcs_pkg::CSR_X_ADDRESS:      x_address_ff <= csr_chan.data[shcs_pkg::ADDR_W-1:0];
            shcs_pkg::CSR_DEBOUNCE_TICKS: debounce_ff  <= csr_chan.data;
            shcs_pkg::CSR_GAP_TICKS:      gap_ff       <= csr_chan.data;
            shcs_pkg::CSR_SETTLE_TICKS:   settle_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign timer_cfg.debounce_ticks = debounce_ff;
   assign timer_cfg.gap_ticks      = gap_ff;
   assign timer_cfg.settle_ticks   = settle_ff;
   assign addr_cfg.y_address       = y_address_ff;
   assign addr_cfg.x_address       = x_address_ff;

   shcs_front #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .timer_cfg  (timer_cfg),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   shcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   shcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .addr_cfg   (addr_cfg),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
